[sv/usb_transfer_descriptor_sequencer_defines.svh]
// assertion macros for the descriptor sequencer
`ifndef USB_TRANSFER_DESCRIPTOR_SEQUENCER_DEFINES_SVH
`define USB_TRANSFER_DESCRIPTOR_SEQUENCER_DEFINES_SVH

// check a property on every clock edge outside reset
`define UTDS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// check a property on every clock edge, reset included
`define UTDS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/utds_pkg.sv]
// shared types and constants of the descriptor sequencer
`timescale 1ns / 1ps

package utds_pkg;

    // parameter defaults
    localparam int DEF_MAX_TRANSFER_BYTES  = 4096;
    localparam int DEF_MAX_PACKET_BYTES    = 64;
    localparam int DEF_CONTROL_CHUNK_BYTES = 64;

    // length field width in the command, covers the largest allowed transfer
    localparam int LEN_W = 14;
    // packet size width, covers 64 bytes
    localparam int PKT_W = 7;

    localparam logic       MODE_START = 1'b0;
    localparam logic       MODE_NEXT  = 1'b1;

    localparam logic [1:0] KIND_CONTROL   = 2'd0;
    localparam logic [1:0] KIND_INTERRUPT = 2'd1;
    localparam logic [1:0] KIND_BULK      = 2'd2;

    localparam logic [7:0] PID_SETUP = 8'h2d;
    localparam logic [7:0] PID_IN    = 8'h69;
    localparam logic [7:0] PID_OUT   = 8'he1;

    localparam logic [10:0] MAXLEN_NULL = 11'h7ff;

    typedef struct packed {
        logic        mode;
        logic [1:0]  transfer_kind;
        logic [7:0]  device_address;
        logic [7:0]  endpoint_field;
        logic [15:0] transfer_length;
        logic [15:0] pkt_size_limit;
        logic [1:0]  toggle_in;
        logic [7:0]  request_type;
        logic [15:0] request_length;
        logic [31:0] data_base;
        logic [31:0] setup_base;
    } t_request;

    typedef struct packed {
        logic        accepted;
        logic        descriptor_valid;
        logic [31:0] status_word;
        logic [31:0] token_word;
        logic [31:0] buffer_word;
        logic        last_descriptor;
        logic        final_toggle;
    } t_result;

    // classified request handed from the front to the back
    typedef struct packed {
        logic             is_next;
        logic             ok;
        logic             ctrl;
        logic [6:0]       addr;
        logic [3:0]       ep;
        logic             dir_in;
        logic             toggle;
        logic [PKT_W-1:0] pkt;
        logic [LEN_W-1:0] len;
        logic [31:0]      data_base;
        logic [31:0]      setup_base;
    } t_cmd;

endpackage

[sv/utds_front.sv]
// front end: packs each request into a command, checking it as a start request
`timescale 1ns / 1ps

module utds_front import utds_pkg::*; #(
    parameter int MAX_TRANSFER_BYTES  = DEF_MAX_TRANSFER_BYTES,
    parameter int MAX_PACKET_BYTES    = DEF_MAX_PACKET_BYTES,
    parameter int CONTROL_CHUNK_BYTES = DEF_CONTROL_CHUNK_BYTES
) (
    input  t_request i_req,
    output t_cmd     o_cmd
);

    logic ctrl;
    logic data_kind;
    logic base_ok;
    logic ctrl_ok;
    logic data_ok;

    always_comb begin
        ctrl      = (i_req.transfer_kind == KIND_CONTROL);
        data_kind = (i_req.transfer_kind == KIND_INTERRUPT) ||
                    (i_req.transfer_kind == KIND_BULK);
        base_ok   = !i_req.device_address[7] &&
                    (i_req.transfer_length <= 16'(MAX_TRANSFER_BYTES));
        ctrl_ok   = (i_req.endpoint_field <= 8'd15) &&
                    (i_req.transfer_length == i_req.request_length);
        data_ok   = (i_req.endpoint_field[6:0] <= 7'd15) &&
                    (i_req.pkt_size_limit != 16'd0) &&
                    (i_req.pkt_size_limit <= 16'(MAX_PACKET_BYTES)) &&
                    !i_req.toggle_in[1] &&
                    !((i_req.transfer_kind == KIND_INTERRUPT) &&
                      (i_req.transfer_length == 16'd0));

        o_cmd.is_next    = (i_req.mode == MODE_NEXT);
        o_cmd.ok         = base_ok && ((ctrl && ctrl_ok) || (data_kind && data_ok));
        o_cmd.ctrl       = ctrl;
        o_cmd.addr       = i_req.device_address[6:0];
        o_cmd.ep         = i_req.endpoint_field[3:0];
        o_cmd.dir_in     = ctrl ? i_req.request_type[7] : i_req.endpoint_field[7];
        o_cmd.toggle     = ctrl ? 1'b1 : i_req.toggle_in[0];
        o_cmd.pkt        = ctrl ? PKT_W'(CONTROL_CHUNK_BYTES) : i_req.pkt_size_limit[PKT_W-1:0];
        o_cmd.len        = i_req.transfer_length[LEN_W-1:0];
        o_cmd.data_base  = i_req.data_base;
        o_cmd.setup_base = i_req.setup_base;
    end

endmodule

[sv/utds_cmd_queue.sv]
// two-entry command queue between front and back
`timescale 1ns / 1ps
`include "usb_transfer_descriptor_sequencer_defines.svh"

module utds_cmd_queue import utds_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    logic r_head_valid, n_head_valid;
    logic r_tail_valid, n_tail_valid;
    t_cmd r_head, n_head;
    t_cmd r_tail, n_tail;

    always_comb begin
        n_head_valid = r_head_valid;
        n_tail_valid = r_tail_valid;
        n_head       = r_head;
        n_tail       = r_tail;
        if (i_pop) begin
            n_head       = r_tail;
            n_head_valid = r_tail_valid;
            n_tail_valid = 1'b0;
            if (i_push) begin
                if (r_tail_valid) begin
                    n_tail       = i_cmd;
                    n_tail_valid = 1'b1;
                end else begin
                    n_head       = i_cmd;
                    n_head_valid = 1'b1;
                end
            end
        end else if (i_push) begin
            if (!r_head_valid) begin
                n_head       = i_cmd;
                n_head_valid = 1'b1;
            end else begin
                n_tail       = i_cmd;
                n_tail_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_tail <= n_tail;
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_tail_valid <= 1'b0;
        end else begin
            r_head_valid <= n_head_valid;
            r_tail_valid <= n_tail_valid;
        end
    end

    assign o_full  = r_tail_valid;
    assign o_valid = r_head_valid;
    assign o_cmd   = r_head;

    `UTDS_ASSERT(a_tail_needs_head, i_clk, i_rst_n, r_tail_valid |-> r_head_valid, "queue tail without head")
    `UTDS_ASSERT(a_push_pop_keeps, i_clk, i_rst_n, (i_push && i_pop && r_head_valid) |=> r_head_valid, "queue lost an entry")

endmodule

[sv/utds_back.sv]
// back end: descriptor sequencer state and the result register
`timescale 1ns / 1ps
`include "usb_transfer_descriptor_sequencer_defines.svh"

module utds_back import utds_pkg::*; #(
    parameter int MAX_TRANSFER_BYTES = DEF_MAX_TRANSFER_BYTES
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  logic    i_cfg_wdata,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    output logic    o_empty,
    input  logic    i_pop,
    output t_result o_result
);

    localparam int BL_W = $clog2(MAX_TRANSFER_BYTES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DATA,
        ST_STATUS
    } t_stage;

    t_stage            r_stage, n_stage;
    logic [BL_W-1:0]   r_bytes_left, n_bytes_left;
    logic              r_toggle, n_toggle;
    logic [6:0]        r_addr, n_addr;
    logic [3:0]        r_ep, n_ep;
    logic              r_dir_in, n_dir_in;
    logic [PKT_W-1:0]  r_pkt, n_pkt;
    logic [31:0]       r_buf_ptr, n_buf_ptr;
    logic [31:0]       r_setup_addr, n_setup_addr;
    logic              r_ctrl, n_ctrl;
    logic              r_low_speed;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;

    logic              fire;
    logic [PKT_W-1:0]  chunk;
    logic              fin;

    function automatic logic [31:0] make_status(input logic ls, input logic ioc);
        logic [31:0] w;
        w     = 32'd0;
        w[28] = 1'b1;
        w[27] = 1'b1;
        w[26] = ls;
        w[24] = ioc;
        w[23] = 1'b1;
        return w;
    endfunction

    function automatic logic [31:0] make_token(input logic [7:0] pid, input logic [6:0] addr,
                                               input logic [3:0] ep, input logic tog,
                                               input logic [10:0] maxlen);
        return {maxlen, 1'b0, tog, ep, addr, pid};
    endfunction

    // a command moves when the result register is free or being drained
    assign fire      = i_cmd_valid && (!r_out_valid || i_pop);
    assign o_cmd_pop = fire;

    always_comb begin
        chunk = (r_bytes_left < BL_W'(r_pkt)) ? r_bytes_left[PKT_W-1:0] : r_pkt;
        fin   = (r_bytes_left <= BL_W'(r_pkt));

        n_stage      = r_stage;
        n_bytes_left = r_bytes_left;
        n_toggle     = r_toggle;
        n_addr       = r_addr;
        n_ep         = r_ep;
        n_dir_in     = r_dir_in;
        n_pkt        = r_pkt;
        n_buf_ptr    = r_buf_ptr;
        n_setup_addr = r_setup_addr;
        n_ctrl       = r_ctrl;
        n_out        = '0;
        n_out_valid  = r_out_valid && !i_pop;

        if (fire) begin
            n_out_valid = 1'b1;
            if (!i_cmd.is_next) begin
                n_out.accepted = i_cmd.ok;
                if (i_cmd.ok) begin
                    n_stage      = i_cmd.ctrl ? ST_SETUP : ST_DATA;
                    n_bytes_left = i_cmd.len[BL_W-1:0];
                    n_toggle     = i_cmd.toggle;
                    n_addr       = i_cmd.addr;
                    n_ep         = i_cmd.ep;
                    n_dir_in     = i_cmd.dir_in;
                    n_pkt        = i_cmd.pkt;
                    n_buf_ptr    = i_cmd.data_base;
                    n_setup_addr = i_cmd.setup_base;
                    n_ctrl       = i_cmd.ctrl;
                end
            end else begin
                case (r_stage)
                    ST_SETUP: begin
                        n_out.descriptor_valid = 1'b1;
                        n_out.status_word = make_status(r_low_speed, 1'b0);
                        n_out.token_word  = make_token(PID_SETUP, r_addr, r_ep, 1'b0, 11'd7);
                        n_out.buffer_word = r_setup_addr;
                        n_stage = (r_bytes_left != '0) ? ST_DATA : ST_STATUS;
                    end
                    ST_STATUS: begin
                        n_out.descriptor_valid = 1'b1;
                        n_out.status_word = make_status(r_low_speed, 1'b1);
                        n_out.token_word  = make_token(r_dir_in ? PID_OUT : PID_IN,
                                                       r_addr, r_ep, 1'b1, MAXLEN_NULL);
                        n_out.last_descriptor = 1'b1;
                        n_stage = ST_IDLE;
                    end
                    ST_DATA: begin
                        n_out.descriptor_valid = 1'b1;
                        n_out.token_word = make_token(r_dir_in ? PID_IN : PID_OUT,
                                                      r_addr, r_ep, r_toggle,
                                                      (chunk == '0) ? MAXLEN_NULL
                                                          : 11'(chunk - PKT_W'(1)));
                        // zero-length data packet points nowhere
                        n_out.buffer_word = (!r_ctrl && chunk == '0) ? 32'd0 : r_buf_ptr;
                        n_toggle     = !r_toggle;
                        n_buf_ptr    = r_buf_ptr + 32'(chunk);
                        n_bytes_left = r_bytes_left - BL_W'(chunk);
                        if (r_ctrl) begin
                            n_out.status_word = make_status(r_low_speed, 1'b0);
                            if (fin) begin
                                n_stage = ST_STATUS;
                            end
                        end else begin
                            n_out.status_word     = make_status(r_low_speed, fin);
                            n_out.final_toggle    = !r_toggle;
                            n_out.last_descriptor = fin;
                            if (fin) begin
                                n_stage = ST_IDLE;
                            end
                        end
                    end
                    default: begin
                        n_out = '0;
                    end
                endcase
            end
        end else if (r_out_valid && !i_pop) begin
            n_out = r_out;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes_left <= n_bytes_left;
        r_toggle     <= n_toggle;
        r_addr       <= n_addr;
        r_ep         <= n_ep;
        r_dir_in     <= n_dir_in;
        r_pkt        <= n_pkt;
        r_buf_ptr    <= n_buf_ptr;
        r_setup_addr <= n_setup_addr;
        r_ctrl       <= n_ctrl;
        r_out        <= n_out;
        if (!i_rst_n) begin
            r_stage     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_low_speed <= 1'b0;
        end else begin
            r_stage     <= n_stage;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_low_speed <= i_cfg_wdata;
            end
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    `UTDS_ASSERT(a_fire_fills, i_clk, i_rst_n, fire |=> r_out_valid, "result register not loaded")
    `UTDS_ASSERT(a_acc_or_desc, i_clk, i_rst_n, r_out_valid |-> !(r_out.accepted && r_out.descriptor_valid), "start and descriptor result mixed")
    `UTDS_ASSERT(a_last_ioc, i_clk, i_rst_n, (r_out_valid && r_out.last_descriptor) |-> (r_out.descriptor_valid && r_out.status_word[24]), "last descriptor without interrupt bit")
    `UTDS_ASSERT(a_idle_after_last, i_clk, i_rst_n, (fire && n_out.last_descriptor) |=> (r_stage == ST_IDLE), "sequencer busy after last descriptor")

endmodule

[sv/usb_transfer_descriptor_sequencer.sv]
// top level of the usb transfer descriptor sequencer
`timescale 1ns / 1ps

// channel   | direction | handshake         | payload
// request   | in        | push / full       | i_req (t_request)
// result    | out       | pop / empty       | o_result (t_result)
// config    | in        | i_cfg_we          | i_cfg_wdata (low-speed device)
//
// one request in and one result out per cycle when neither side stalls
// each request passes through the command queue and then the back-end result register
// before it shows on the ports
// the back end takes a new request while its result register is free or being drained
// a stalled result side fills the two-entry queue, after which full rises
// reset is synchronous and empties the queue and the result register

module usb_transfer_descriptor_sequencer import utds_pkg::*; #(
    parameter int MAX_TRANSFER_BYTES  = DEF_MAX_TRANSFER_BYTES,
    parameter int MAX_PACKET_BYTES    = DEF_MAX_PACKET_BYTES,
    parameter int CONTROL_CHUNK_BYTES = DEF_CONTROL_CHUNK_BYTES
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    // request side
    input  logic     push,
    output logic     full,
    input  t_request i_req,
    // result side
    output logic     empty,
    input  logic     pop,
    output t_result  o_result,
    // low-speed device register
    input  logic     i_cfg_we,
    input  logic     i_cfg_wdata
);

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic queue_valid;
    logic queue_pop;
    logic queue_push;

    // a request enters when the queue has room
    assign queue_push = push && !full;

    // check and classify the request as it arrives
    utds_front #(
        .MAX_TRANSFER_BYTES (MAX_TRANSFER_BYTES),
        .MAX_PACKET_BYTES   (MAX_PACKET_BYTES),
        .CONTROL_CHUNK_BYTES(CONTROL_CHUNK_BYTES)
    ) u_front (
        .i_req (i_req),
        .o_cmd (front_cmd)
    );

    // decouples the request side from result stalls
    utds_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (queue_push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    // runs the descriptor sequence and holds the outgoing result
    utds_back #(
        .MAX_TRANSFER_BYTES (MAX_TRANSFER_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (queue_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule
